### rtl/core/fupe_pkg.sv
package fupe_pkg;

  localparam logic [15:0] CAP_RESET = 16'd4096;

  // Register indexes of the configuration port.
  localparam logic REG_OUT_CAPACITY = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int HEAD_LEN = 7;
  localparam int TAIL_LEN = 12;

  localparam logic [7:0] CHAR_SLASH     = "/";
  localparam logic [7:0] CHAR_BACKSLASH = "\\";
  localparam logic [7:0] CHAR_PERCENT   = "%";

  // How the body of one path byte is written out.
  localparam logic [1:0] BODY_NONE  = 2'd0;
  localparam logic [1:0] BODY_PLAIN = 2'd1;
  localparam logic [1:0] BODY_ESC   = 2'd2;

  // One unit of output work, produced by the front end for one item.
  typedef struct packed {
    logic       head;
    logic       slash;
    logic [1:0] body;
    logic [7:0] ch;
    logic       tail;
    logic       err;
  } job_t;

  function automatic logic [7:0] head_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "f";
      3'd1:    c = "i";
      3'd2:    c = "l";
      3'd3:    c = "e";
      3'd4:    c = ":";
      default: c = "/";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tail_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "?";
      4'd1:    c = "i";
      4'd2:    c = "m";
      4'd3:    c = "m";
      4'd4:    c = "u";
      4'd5:    c = "t";
      4'd6:    c = "a";
      4'd7:    c = "b";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "=";
      default: c = "1";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic is_plain(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == "/" || c == "." || c == "-" ||
           c == "_" || c == "~" || c == ":";
  endfunction

endpackage

### rtl/core/fupe_in_if.sv
interface fupe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       byte_valid;
  logic       last_item;

  modport source (output valid, output path_byte, output byte_valid, output last_item,
                  input ready);
  modport sink (input valid, input path_byte, input byte_valid, input last_item,
                output ready);
endinterface

### rtl/core/fupe_out_if.sv
interface fupe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_valid;
  logic       status;
  logic       out_last;

  modport source (output valid, output out_char, output out_valid, output status,
                  output out_last, input ready);
  modport sink (input valid, input out_char, input out_valid, input status,
                input out_last, output ready);
endinterface

### rtl/core/file_uri_percent_encoder.sv
// File path to file URI encoder.
// The path channel takes one path byte per item (path_byte, byte_valid,
// last_item); the uri channel returns one result per character of
// "file://" [+ "/"] + encoded path + "?immutable=1". Bytes outside the plain
// set are sent as a percent sign and two upper-case hex digits.
// An empty path is one item with byte_valid low and last_item high.
// out_capacity (APB, byte address 0) bounds the URI length, one slot being
// kept for a terminator; on overflow a single result with status high and
// out_last high ends the run, and input is dropped up to the next last item.
// An item's first character passes the job queue, the job register and the
// output register on its way out. The back end sends one character per
// cycle while the receiver is ready and jobs are queued, so throughput follows
// the character count: one per plain byte, three per escaped byte, plus seven
// or eight for the prefix and twelve for the suffix. A four-entry job queue
// lets the front end keep accepting items while the back end works; path.ready
// drops only when that queue is full. When the receiver stalls, the current
// character holds on the uri channel and the back end waits. Reset empties
// the queue, ends any run in progress and sets out_capacity back to 4096.
module file_uri_percent_encoder (
  input  logic        clk,
  input  logic        rst,
  fupe_in_if.sink     path,
  fupe_out_if.source  uri,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fupe_pkg::*;

  logic [15:0] out_capacity;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  job_t        push_job;
  job_t        pop_job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? {16'd0, out_capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_CAPACITY) begin
      out_capacity <= pwdata[15:0];
    end
  end

  fupe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .path     (path),
    .capacity (out_capacity),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  fupe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  fupe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .pop_job (pop_job),
    .pop     (pop),
    .uri     (uri)
  );

endmodule

### rtl/core/fupe_front.sv
module fupe_front (
  input  logic          clk,
  input  logic          rst,
  fupe_in_if.sink       path,
  input  logic [15:0]   capacity,
  input  logic          full,
  output logic          push,
  output fupe_pkg::job_t push_job
);
  import fupe_pkg::*;

  logic        started;
  logic        started_next;
  logic [15:0] position;
  logic [15:0] position_next;
  logic        failed;
  logic        failed_next;
  logic        accept;
  logic        abort;
  logic        want_push;
  logic [16:0] cap;
  logic [16:0] pos_a;
  logic [16:0] pos_b;
  logic [7:0]  c;
  job_t        job;

  assign path.ready = !full;
  assign accept     = path.valid && path.ready;
  assign cap        = {1'b0, capacity};

  always_comb begin
    job           = '0;
    abort         = 1'b0;
    want_push     = 1'b0;
    started_next  = started;
    position_next = position;
    failed_next   = failed;
    pos_a         = {1'b0, position};
    pos_b         = pos_a;
    c             = (path.path_byte == CHAR_BACKSLASH) ? CHAR_SLASH : path.path_byte;

    if (failed) begin
      // Input is dropped until the end of the aborted path.
      if (path.last_item) begin
        started_next  = 1'b0;
        position_next = '0;
        failed_next   = 1'b0;
      end
    end else if (path.byte_valid || path.last_item) begin
      want_push = 1'b1;
      if (!started) begin
        if (cap < 17'd8) begin
          abort = 1'b1;
        end else begin
          job.head = 1'b1;
          pos_a    = 17'(HEAD_LEN);
          if (!path.byte_valid || path.path_byte != CHAR_SLASH) begin
            if (cap <= 17'd8) begin
              abort = 1'b1;
            end else begin
              job.slash = 1'b1;
              pos_a     = 17'(HEAD_LEN + 1);
            end
          end
        end
      end
      pos_b = pos_a;
      if (!abort && path.byte_valid) begin
        job.ch = c;
        if (is_plain(c)) begin
          if (pos_a + 17'd1 >= cap) begin
            abort = 1'b1;
          end else begin
            job.body = BODY_PLAIN;
            pos_b    = pos_a + 17'd1;
          end
        end else begin
          if (pos_a + 17'd3 >= cap) begin
            abort = 1'b1;
          end else begin
            job.body = BODY_ESC;
            pos_b    = pos_a + 17'd3;
          end
        end
      end
      if (!abort && path.last_item) begin
        if (pos_b + 17'(TAIL_LEN + 1) > cap) begin
          abort = 1'b1;
        end else begin
          job.tail = 1'b1;
        end
      end
      job.err = abort;
      if (abort || path.last_item) begin
        started_next  = 1'b0;
        position_next = '0;
        failed_next   = abort && !path.last_item;
      end else begin
        started_next  = 1'b1;
        position_next = pos_b[15:0];
      end
    end
  end

  assign push     = accept && want_push;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      position <= '0;
      failed   <= 1'b0;
    end else if (accept) begin
      started  <= started_next;
      position <= position_next;
      failed   <= failed_next;
    end
  end

endmodule

### rtl/core/fupe_queue.sv
module fupe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fupe_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output fupe_pkg::job_t pop_job,
  output logic           empty
);
  import fupe_pkg::*;

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full    = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/fupe_back.sv
module fupe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  fupe_pkg::job_t pop_job,
  output logic           pop,
  fupe_out_if.source     uri
);
  import fupe_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HEAD  = 3'd1;
  localparam logic [2:0] PH_SLASH = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_TAIL  = 3'd4;
  localparam logic [2:0] PH_ERR   = 3'd5;

  // First phase of the job that comes after phase p, in output order.
  function automatic logic [2:0] phase_after(input job_t j, input logic [2:0] p);
    logic [4:0] en;
    logic [2:0] r;
    en = {j.err, j.tail, j.body != BODY_NONE, j.slash, j.head};
    r  = PH_IDLE;
    for (int k = 5; k >= 1; k--) begin
      if (en[k-1] && 3'(k) > p) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

  job_t       cur;
  logic       cur_vld;
  logic [2:0] phase;
  logic [3:0] idx;
  logic       advance;
  logic       phase_end;
  logic [2:0] np;
  logic       job_done;
  logic [7:0] em_char;
  logic       em_ov;
  logic       em_st;
  logic       em_last;

  logic       o_vld;
  logic [7:0] o_char;
  logic       o_ov;
  logic       o_st;
  logic       o_last;

  assign advance = cur_vld && (!o_vld || uri.ready);

  always_comb begin
    em_char   = '0;
    em_ov     = 1'b1;
    em_st     = 1'b0;
    em_last   = 1'b0;
    phase_end = 1'b1;
    unique case (phase)
      PH_HEAD: begin
        em_char   = head_char(idx[2:0]);
        phase_end = idx == 4'(HEAD_LEN - 1);
      end
      PH_SLASH: begin
        em_char = CHAR_SLASH;
      end
      PH_BODY: begin
        if (cur.body == BODY_PLAIN) begin
          em_char = cur.ch;
        end else begin
          phase_end = idx == 4'd2;
          case (idx[1:0])
            2'd0:    em_char = CHAR_PERCENT;
            2'd1:    em_char = hex_char(cur.ch[7:4]);
            default: em_char = hex_char(cur.ch[3:0]);
          endcase
        end
      end
      PH_TAIL: begin
        em_char   = tail_char(idx);
        phase_end = idx == 4'(TAIL_LEN - 1);
        em_last   = phase_end;
      end
      PH_ERR: begin
        em_ov   = 1'b0;
        em_st   = 1'b1;
        em_last = 1'b1;
      end
      default: begin
        em_ov = 1'b0;
      end
    endcase
  end

  assign np       = phase_after(cur, phase);
  assign job_done = advance && phase_end && np == PH_IDLE;
  assign pop      = !empty && (!cur_vld || job_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld <= 1'b0;
      phase   <= PH_IDLE;
      idx     <= '0;
    end else if (pop) begin
      cur_vld <= 1'b1;
      cur     <= pop_job;
      phase   <= phase_after(pop_job, PH_IDLE);
      idx     <= '0;
    end else if (job_done) begin
      cur_vld <= 1'b0;
      phase   <= PH_IDLE;
      idx     <= '0;
    end else if (advance) begin
      if (phase_end) begin
        phase <= np;
        idx   <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Output register: the next character is loaded as soon as the current one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (advance) begin
      o_vld <= 1'b1;
    end else if (uri.ready) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_char <= em_char;
      o_ov   <= em_ov;
      o_st   <= em_st;
      o_last <= em_last;
    end
  end

  assign uri.valid     = o_vld;
  assign uri.out_char  = o_char;
  assign uri.out_valid = o_ov;
  assign uri.status    = o_st;
  assign uri.out_last  = o_last;

`ifndef SYNTHESIS
  a_busy_has_phase: assert property (@(posedge clk) disable iff (rst)
    cur_vld |-> phase != PH_IDLE)
    else $error("active job without a phase");
  a_tail_flagged: assert property (@(posedge clk) disable iff (rst)
    cur_vld && phase == PH_TAIL |-> cur.tail && !cur.err)
    else $error("suffix phase on a job without a suffix");
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    cur_vld && phase == PH_HEAD |-> idx < 4'(HEAD_LEN))
    else $error("prefix index out of range");
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    o_vld && o_st |-> o_last && !o_ov && o_char == 8'd0)
    else $error("malformed error result");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fupe_pkg::*;

  localparam int TXT_LEN     = 24;
  localparam int DIR_N       = 26;
  localparam int RAND_ITEMS  = 424;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_SLACK = 16;
  localparam logic [2:0] CAP_ADDR = {REG_OUT_CAPACITY, 2'b00};

  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic       st;
    logic       lst;
  } uri_char_t;

  typedef struct packed {
    logic                 set_cap;
    logic [15:0]          cap;
    logic [7:0]           b;
    logic                 bv;
    logic                 lst;
    logic                 typed;
    logic                 err;
    logic [8*TXT_LEN-1:0] txt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fupe_in_if  path_if ();
  fupe_out_if uri_if ();

  file_uri_percent_encoder u_top (
    .clk     (clk),
    .rst     (rst),
    .path    (path_if),
    .uri     (uri_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Encoder model state and its copy of the capacity register.
  logic [15:0] cap_reg = CAP_RESET;
  bit          run_started = 1'b0;
  int          run_pos = 0;
  bit          run_failed = 1'b0;
  string       uri_head = "file://";
  string       uri_tail = "?immutable=1";

  uri_char_t   uri_chars_due[$];
  uri_char_t   item_chars[$];

  int src_idle_pct = 17;
  int snk_idle_pct = 70;
  int hold_asked = 0;

  int n_bad = 0;
  int n_cfg_bad = 0;
  int n_chars = 0;
  int n_overflow = 0;
  int n_cap_writes = 0;

  dir_row_t dir_rows [DIR_N];

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h41 + 8'(nib) - 8'd10);
  endfunction

  function automatic bit passes_plain(input logic [7:0] c);
    return (c inside {["A":"Z"], ["a":"z"], ["0":"9"]}) ||
           (c inside {"/", ".", "-", "_", "~", ":"});
  endfunction

  function automatic void put_char(input logic [7:0] ch, input logic lst);
    item_chars.push_back('{ch, 1'b1, 1'b0, lst});
  endfunction

  function automatic void end_run();
    run_started = 1'b0;
    run_pos = 0;
    run_failed = 1'b0;
  endfunction

  function automatic void put_overflow(input bit lst);
    item_chars.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
    end_run();
    run_failed = !lst;
  endfunction

  // Appends the characters one path item causes to item_chars and returns their count.
  function automatic int encode_path_item(input logic [7:0] b, input logic bv,
                                          input logic lst);
    logic [7:0] c;
    int         cap;
    cap = int'(cap_reg);
    if (run_failed) begin
      if (lst) end_run();
      return 0;
    end
    if (!bv && !lst) return 0;
    if (!run_started) begin
      if (8 > cap) begin
        put_overflow(lst);
        return item_chars.size();
      end
      for (int i = 0; i < 7; i++) put_char(uri_head[i], 1'b0);
      run_pos = 7;
      run_started = 1'b1;
      if (!bv || b != CHAR_SLASH) begin
        if (run_pos + 1 >= cap) begin
          put_overflow(lst);
          return item_chars.size();
        end
        put_char(CHAR_SLASH, 1'b0);
        run_pos++;
      end
    end
    if (bv) begin
      c = (b == CHAR_BACKSLASH) ? CHAR_SLASH : b;
      if (passes_plain(c)) begin
        if (run_pos + 1 >= cap) begin
          put_overflow(lst);
          return item_chars.size();
        end
        put_char(c, 1'b0);
        run_pos++;
      end else begin
        if (run_pos + 3 >= cap) begin
          put_overflow(lst);
          return item_chars.size();
        end
        put_char(CHAR_PERCENT, 1'b0);
        put_char(hex_digit(c[7:4]), 1'b0);
        put_char(hex_digit(c[3:0]), 1'b0);
        run_pos += 3;
      end
    end
    if (lst) begin
      if (run_pos + 13 > cap) begin
        put_overflow(1'b1);
        return item_chars.size();
      end
      for (int i = 0; i < 12; i++) put_char(uri_tail[i], (i == 11));
      end_run();
    end
    return item_chars.size();
  endfunction

  task automatic offer_path_item(input logic [7:0] b, input logic bv, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      path_if.valid <= 1'b0;
      @(posedge clk);
    end
    path_if.valid      <= 1'b1;
    path_if.path_byte  <= b;
    path_if.byte_valid <= bv;
    path_if.last_item  <= lst;
    @(posedge clk);
    while (!path_if.ready) @(posedge clk);
  endtask

  task automatic wait_uri_drained();
    path_if.valid <= 1'b0;
    while (uri_chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic read_back_capacity();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CAP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== cap_reg) begin
      if (n_cfg_bad < 10)
        $display("%0t out_capacity read back %h, expected %h", $realtime, prdata[15:0],
                 cap_reg);
      n_cfg_bad++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Capacity changes only once every expected character has come out.
  task automatic set_capacity(input logic [15:0] v);
    wait_uri_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_reg = v;
    n_cap_writes++;
    read_back_capacity();
  endtask

  initial begin : uri_sink
    uri_char_t seen;
    uri_char_t want;
    int        hold_left;
    int        hold_taken;
    hold_left = 0;
    hold_taken = 0;
    uri_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        uri_if.ready <= 1'b0;
      end else begin
        if (uri_if.valid && uri_if.ready) begin
          seen = '{uri_if.out_char, uri_if.out_valid, uri_if.status, uri_if.out_last};
          if (uri_chars_due.size() == 0) begin
            if (n_bad < 10)
              $display("%0t unexpected item: char %h valid %b status %b last %b",
                       $realtime, seen.ch, seen.vld, seen.st, seen.lst);
            n_bad++;
          end else begin
            want = uri_chars_due.pop_front();
            if (seen !== want) begin
              if (n_bad < 10)
                $display("%0t mismatch (exp/got): char %h/%h valid %b/%b status %b/%b last %b/%b",
                         $realtime, want.ch, seen.ch, want.vld, seen.vld, want.st, seen.st,
                         want.lst, seen.lst);
              n_bad++;
            end
            if (want.st) n_overflow++;
            else n_chars++;
          end
        end
        if (hold_asked != hold_taken) begin
          hold_taken = hold_asked;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          uri_if.ready <= 1'b0;
        end else begin
          uri_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
      end
    end
  end

  initial begin
    #(6_000_000);
    $display("file_uri_percent_encoder verification failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   row;
    logic [7:0] b;
    logic       bv;
    logic       lst;
    logic [7:0] ch;
    int         n_rand;
    int         plen;
    int         phase;
    string      marks;

    marks = "/.-_~:";
    n_rand = 0;
    phase = 0;
    path_if.valid      <= 1'b0;
    path_if.path_byte  <= 8'h00;
    path_if.byte_valid <= 1'b0;
    path_if.last_item  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'd0;
    pwdata  <= 32'd0;

    dir_rows = '{
      '{1'b0, 16'd0,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, "file:///?immutable=1"},
      '{1'b0, 16'd0,     8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ""},
      '{1'b0, 16'd0,     "/",   1'b1, 1'b0, 1'b1, 1'b0, "file:///"},
      '{1'b0, 16'd0,     8'h00, 1'b1, 1'b0, 1'b1, 1'b0, "%00"},
      '{1'b0, 16'd0,     8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, "%FF"},
      '{1'b0, 16'd0,     8'h5C, 1'b1, 1'b0, 1'b1, 1'b0, "/"},
      '{1'b0, 16'd0,     "A",   1'b1, 1'b0, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     "z",   1'b1, 1'b0, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     "0",   1'b1, 1'b0, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     "~",   1'b1, 1'b0, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     ":",   1'b1, 1'b0, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     8'h20, 1'b1, 1'b0, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     "%",   1'b1, 1'b1, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     "x",   1'b1, 1'b0, 1'b0, 1'b0, ""},
      '{1'b0, 16'd0,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, "?immutable=1"},
      '{1'b1, 16'd1,     "/",   1'b1, 1'b1, 1'b1, 1'b1, ""},
      '{1'b1, 16'd7,     "a",   1'b1, 1'b0, 1'b1, 1'b1, ""},
      '{1'b0, 16'd0,     "b",   1'b1, 1'b0, 1'b1, 1'b0, ""},
      '{1'b0, 16'd0,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, ""},
      '{1'b1, 16'd8,     "/",   1'b1, 1'b0, 1'b1, 1'b1, "file://"},
      '{1'b0, 16'd0,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, ""},
      '{1'b1, 16'd20,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, "file:///"},
      '{1'b1, 16'd21,    8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ""},
      '{1'b1, 16'd65535, "p",   1'b1, 1'b0, 1'b0, 1'b0, ""},
      '{1'b1, 16'd12,    "q",   1'b1, 1'b1, 1'b0, 1'b0, ""}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_back_capacity();

    for (int r = 0; r < DIR_N; r++) begin
      row = dir_rows[r];
      if (row.set_cap) set_capacity(row.cap);
      offer_path_item(row.b, row.bv, row.lst);
      item_chars.delete();
      void'(encode_path_item(row.b, row.bv, row.lst));
      if (row.typed) begin
        // Typed text is right-justified; the final character sits in the low byte.
        for (int k = TXT_LEN - 1; k >= 0; k--) begin
          ch = row.txt[8*k +: 8];
          if (ch != 8'h00)
            uri_chars_due.push_back('{ch, 1'b1, 1'b0, (k == 0) && row.lst && !row.err});
        end
        if (row.err) uri_chars_due.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      end else begin
        foreach (item_chars[i]) uri_chars_due.push_back(item_chars[i]);
      end
    end

    while (n_rand < RAND_ITEMS) begin
      if (n_rand >= 300 && phase == 1) begin
        wait_uri_drained();
        phase = 2;
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (n_rand >= 150 && phase == 0) begin
        wait_uri_drained();
        phase = 1;
        src_idle_pct = 70;
        snk_idle_pct = 17;
      end
      // No capacity writes right after the long stall starts, so the sender keeps pushing.
      if ($urandom_range(99) < 30 && !(hold_asked == 1 && n_rand < 360)) begin
        case ($urandom_range(5))
          0: set_capacity(16'd4096);
          1: set_capacity(16'd65535);
          2: set_capacity(16'($urandom_range(1, 24)));
          3: set_capacity(16'($urandom_range(20, 80)));
          4: set_capacity(16'($urandom_range(1, 65535)));
          default: set_capacity(16'($urandom_range(8, 300)));
        endcase
      end
      plen = ($urandom_range(99) < 5) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int k = 0; k <= plen; k++) begin
        lst = (k == plen);
        if ($urandom_range(99) < 8) begin
          b = 8'($urandom);
          bv = 1'($urandom);
          lst = 1'($urandom);
        end else begin
          bv = !((lst && $urandom_range(99) < 20) || (!lst && $urandom_range(99) < 5));
          case ($urandom_range(7))
            0: b = 8'("A" + $urandom_range(25));
            1: b = 8'("a" + $urandom_range(25));
            2: b = 8'("0" + $urandom_range(9));
            3: b = marks[$urandom_range(5)];
            4: b = CHAR_BACKSLASH;
            default: b = 8'($urandom_range(255));
          endcase
        end
        offer_path_item(b, bv, lst);
        item_chars.delete();
        void'(encode_path_item(b, bv, lst));
        foreach (item_chars[i]) uri_chars_due.push_back(item_chars[i]);
        n_rand++;
        // One long receiver stall while the sender keeps pushing with no gaps.
        if (phase == 2 && n_rand >= 320 && hold_asked == 0) hold_asked = 1;
      end
    end

    wait_uri_drained();
    $display("Summary: %0d directed rows, %0d random items, %0d characters, %0d overflows",
             DIR_N, n_rand, n_chars, n_overflow);
    $display("Summary: %0d capacity writes from 1 to 65535, three idle mixes, one long receiver stall",
             n_cap_writes);
    if (n_bad == 0 && n_cfg_bad == 0) begin
      $display("file_uri_percent_encoder verification clean");
    end else begin
      $display("file_uri_percent_encoder verification failed");
    end
    $finish;
  end

endmodule
